[design/lsnd_pkg.sv]
// Shared constants, calibration tables and types for the line sensor normalizer.
package lsnd_pkg;

  // Sample and field widths.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned FIELD_BITS  = 12;
  localparam int unsigned NORM_BITS   = 11;
  localparam int unsigned STEER_BITS  = 12;
  localparam int unsigned MASK_BITS   = 5;
  localparam int unsigned NUM_LANES   = 5;

  // Only the low SAMPLE_BITS bits of a sample take part.
  localparam logic [FIELD_BITS-1:0] SAMPLE_MASK =
    FIELD_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Normalized scale and floor.
  localparam logic [NORM_BITS-1:0] NORM_MAX   = NORM_BITS'(2000);
  localparam logic [NORM_BITS-1:0] NORM_FLOOR = NORM_BITS'(20);

  // Width of the scaled offset (offset times the scale) and of the reciprocal.
  localparam int unsigned P_BITS     = FIELD_BITS + NORM_BITS;
  localparam int unsigned RECIP_BITS = 14;
  localparam int unsigned PROD_BITS  = P_BITS + RECIP_BITS;
  localparam longint unsigned RECIP_ONE = 64'd1 << P_BITS;

  // Fixed calibration, lane 0 is far right, lane 4 is far left.
  localparam int unsigned MIN_FR = 180, MAX_FR = 1715;
  localparam int unsigned MIN_RT = 169, MAX_RT = 1473;
  localparam int unsigned MIN_CT = 167, MAX_CT = 1315;
  localparam int unsigned MIN_LT = 163, MAX_LT = 1184;
  localparam int unsigned MIN_FL = 175, MAX_FL = 1437;

  localparam int unsigned SPAN_FR = MAX_FR - MIN_FR;
  localparam int unsigned SPAN_RT = MAX_RT - MIN_RT;
  localparam int unsigned SPAN_CT = MAX_CT - MIN_CT;
  localparam int unsigned SPAN_LT = MAX_LT - MIN_LT;
  localparam int unsigned SPAN_FL = MAX_FL - MIN_FL;

  localparam logic [FIELD_BITS-1:0] CAL_MIN [NUM_LANES] = '{
    FIELD_BITS'(MIN_FR), FIELD_BITS'(MIN_RT), FIELD_BITS'(MIN_CT),
    FIELD_BITS'(MIN_LT), FIELD_BITS'(MIN_FL)
  };

  localparam logic [NORM_BITS-1:0] CAL_SPAN [NUM_LANES] = '{
    NORM_BITS'(SPAN_FR), NORM_BITS'(SPAN_RT), NORM_BITS'(SPAN_CT),
    NORM_BITS'(SPAN_LT), NORM_BITS'(SPAN_FL)
  };

  // floor(2^P_BITS / span): the estimate it gives is low by at most one.
  localparam logic [RECIP_BITS-1:0] CAL_RECIP [NUM_LANES] = '{
    RECIP_BITS'(RECIP_ONE / SPAN_FR), RECIP_BITS'(RECIP_ONE / SPAN_RT),
    RECIP_BITS'(RECIP_ONE / SPAN_CT), RECIP_BITS'(RECIP_ONE / SPAN_LT),
    RECIP_BITS'(RECIP_ONE / SPAN_FL)
  };

  // Lane indexes.
  localparam int unsigned LANE_FR = 0;
  localparam int unsigned LANE_RT = 1;
  localparam int unsigned LANE_CT = 2;
  localparam int unsigned LANE_LT = 3;
  localparam int unsigned LANE_FL = 4;

  // Register indexes of the configuration port.
  localparam int unsigned REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_THR_FR = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_THR_RT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_THR_CT = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_THR_LT = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_THR_FL = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_GATE   = 3'd5;
  localparam int unsigned ADDR_BITS = REG_IDX_BITS + 2;

  localparam logic [NORM_BITS-1:0]  THR_RESET  = NORM_BITS'(1000);
  localparam logic [FIELD_BITS-1:0] GATE_RESET = FIELD_BITS'(300);

  // Stream widths.
  localparam int unsigned IN_BITS  = 80;
  localparam int unsigned OUT_BITS = 80;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [NUM_LANES-1:0][NORM_BITS-1:0] thresh;
    logic [FIELD_BITS-1:0]               gate_thr;
  } cfg_t;

  // Stage advance enables shared by all lanes.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_ctrl_t;

endpackage

[design/lsnd_cfg.sv]
// Configuration registers behind the APB-style port.
module lsnd_cfg import lsnd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t                    cfg_q, cfg_d;
  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode; writes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_THR_FR: cfg_d.thresh[LANE_FR] = pwdata[NORM_BITS-1:0];
        REG_THR_RT: cfg_d.thresh[LANE_RT] = pwdata[NORM_BITS-1:0];
        REG_THR_CT: cfg_d.thresh[LANE_CT] = pwdata[NORM_BITS-1:0];
        REG_THR_LT: cfg_d.thresh[LANE_LT] = pwdata[NORM_BITS-1:0];
        REG_THR_FL: cfg_d.thresh[LANE_FL] = pwdata[NORM_BITS-1:0];
        REG_GATE:   cfg_d.gate_thr        = pwdata[FIELD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh   <= {NUM_LANES{THR_RESET}};
      cfg_q.gate_thr <= GATE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_THR_FR: prdata = 32'(cfg_q.thresh[LANE_FR]);
      REG_THR_RT: prdata = 32'(cfg_q.thresh[LANE_RT]);
      REG_THR_CT: prdata = 32'(cfg_q.thresh[LANE_CT]);
      REG_THR_LT: prdata = 32'(cfg_q.thresh[LANE_LT]);
      REG_THR_FL: prdata = 32'(cfg_q.thresh[LANE_FL]);
      REG_GATE:   prdata = 32'(cfg_q.gate_thr);
      default:    prdata = 32'd0;
    endcase
  end

endmodule

[design/lsnd_lane.sv]
// One sensor lane: three-stage normalize, clamp and threshold pipeline.
module lsnd_lane import lsnd_pkg::*; (
  input  logic                  clk_i,
  input  lane_ctrl_t            ctrl_i,
  input  logic [FIELD_BITS-1:0] sample_i,
  input  logic [FIELD_BITS-1:0] cal_min_i,
  input  logic [NORM_BITS-1:0]  cal_span_i,
  input  logic [RECIP_BITS-1:0] cal_recip_i,
  input  logic [NORM_BITS-1:0]  thresh_i,
  output logic [NORM_BITS-1:0]  norm_o,
  output logic                  line_o
);

  logic [FIELD_BITS-1:0] x, d;
  logic                  low, high;
  logic [P_BITS-1:0]     p;

  logic [P_BITS-1:0]     p1_q, p2_q;
  logic                  low1_q, high1_q, low2_q, high2_q;
  logic [PROD_BITS-1:0]  prod;
  logic [NORM_BITS-1:0]  qest2_q;

  logic [P_BITS-1:0]     qs, rem;
  logic [NORM_BITS-1:0]  q, norm;
  logic [NORM_BITS-1:0]  norm_q;
  logic                  line_q;

  // Offset from the calibration minimum, range flags, and scaled offset.
  always_comb begin
    x    = sample_i & SAMPLE_MASK;
    low  = (x <= cal_min_i);
    d    = x - cal_min_i;
    high = !low && (d >= FIELD_BITS'(cal_span_i));
    p    = P_BITS'(d) * P_BITS'(NORM_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      p1_q    <= p;
      low1_q  <= low;
      high1_q <= high;
    end
  end

  // Quotient estimate by reciprocal multiply; valid whenever the sample is in range.
  assign prod = PROD_BITS'(p1_q) * PROD_BITS'(cal_recip_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      p2_q    <= p1_q;
      low2_q  <= low1_q;
      high2_q <= high1_q;
      qest2_q <= prod[P_BITS +: NORM_BITS];
    end
  end

  // The estimate is low by at most one: one compare fixes it, then clamp.
  always_comb begin
    qs  = P_BITS'(qest2_q) * P_BITS'(cal_span_i);
    rem = p2_q - qs;
    q   = qest2_q + NORM_BITS'(rem >= P_BITS'(cal_span_i));
    if (low2_q) begin
      norm = NORM_FLOOR;
    end else if (high2_q) begin
      norm = NORM_MAX;
    end else if (q < NORM_FLOOR) begin
      norm = NORM_FLOOR;
    end else begin
      norm = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      norm_q <= norm;
      line_q <= (norm < thresh_i);
    end
  end

  assign norm_o = norm_q;
  assign line_o = line_q;

endmodule

[design/lsnd_merge.sv]
// Merge stage: masks the lane flags, forms the steering error, holds the output item.
module lsnd_merge import lsnd_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [NUM_LANES-1:0][NORM_BITS-1:0] norm_i,
  input  logic [NUM_LANES-1:0]                line_i,
  input  logic [MASK_BITS-1:0]                mask_i,
  input  logic                                gate_i,
  output logic                                take_o,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [OUT_BITS-1:0]                 m_axis_tdata
);

  logic                  valid_q;
  logic [OUT_BITS-1:0]   data_q;
  logic [STEER_BITS-1:0] steer;
  logic [MASK_BITS-1:0]  bits;

  // The output register can load when empty or when its item leaves.
  assign take_o = !valid_q || m_axis_tready;

  always_comb begin
    steer = STEER_BITS'(norm_i[LANE_LT]) - STEER_BITS'(norm_i[LANE_RT]);
    bits  = line_i & mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      data_q <= OUT_BITS'({gate_i, steer, bits, norm_i});
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

[design/line_sensor_normalize_digitize.sv]
// Top level of the five-lane line sensor normalizer and digitizer.
//
//  Channel   Direction  Handshake                 Contents
//  s_axis    in         s_axis_tvalid/tready      one set of samples per item
//  m_axis    out        m_axis_tvalid/tready      normalized levels and flags per item
//  apb       in         psel/penable, pready=1    six threshold registers
//
//  One item per cycle sustained while m_axis_tready stays high; an accepted item
//  passes through three lane stages (offset and scale, reciprocal multiply,
//  correction and clamp) and the merge register before m_axis_tvalid.
//  Reset clears the stage valid bits and loads the threshold defaults.
//  Each stage moves on when it is empty or the next one moves, so the input
//  keeps accepting into free stages while a result waits at the output.
module line_sensor_normalize_digitize import lsnd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0: sample_far_right, sample_right, sample_center,
  // sample_left, sample_far_left, gate_sample (12 bits each), bit_mask (5).
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_BITS-1:0]   s_axis_tdata,
  // Fields from bit 0: norm_far_right, norm_right, norm_center, norm_left,
  // norm_far_left (11 bits each), line_bits (5), steer_error (12), gate_open (1).
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_BITS-1:0]  m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t                                cfg;
  lane_ctrl_t                          ctrl;
  logic                                take;
  logic                                v1_q, v2_q, v3_q;
  logic [NUM_LANES-1:0][NORM_BITS-1:0] norm;
  logic [NUM_LANES-1:0]                line;
  logic [MASK_BITS-1:0]                mask1_q, mask2_q, mask3_q;
  logic                                gate1_q, gate2_q, gate3_q;
  logic [FIELD_BITS-1:0]               gate_smp;

  lsnd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage enables, from the output back to the input.
  always_comb begin
    ctrl.en3 = !v3_q || take;
    ctrl.en2 = !v2_q || ctrl.en3;
    ctrl.en1 = !v1_q || ctrl.en2;
  end
  assign s_axis_tready = ctrl.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ctrl.en1) v1_q <= s_axis_tvalid;
      if (ctrl.en2) v2_q <= v1_q;
      if (ctrl.en3) v3_q <= v2_q;
    end
  end

  // Gate compare happens on entry; mask and gate flag ride along the lanes.
  assign gate_smp = s_axis_tdata[NUM_LANES*FIELD_BITS +: FIELD_BITS] & SAMPLE_MASK;

  always_ff @(posedge clk_i) begin
    if (ctrl.en1) begin
      mask1_q <= s_axis_tdata[(NUM_LANES+1)*FIELD_BITS +: MASK_BITS];
      gate1_q <= (gate_smp <= cfg.gate_thr);
    end
    if (ctrl.en2) begin
      mask2_q <= mask1_q;
      gate2_q <= gate1_q;
    end
    if (ctrl.en3) begin
      mask3_q <= mask2_q;
      gate3_q <= gate2_q;
    end
  end

  // Five lanes, one per sensor.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lsnd_lane u_lane (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sample_i    (s_axis_tdata[g*FIELD_BITS +: FIELD_BITS]),
      .cal_min_i   (CAL_MIN[g]),
      .cal_span_i  (CAL_SPAN[g]),
      .cal_recip_i (CAL_RECIP[g]),
      .thresh_i    (cfg.thresh[g]),
      .norm_o      (norm[g]),
      .line_o      (line[g])
    );
  end

  lsnd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v3_q),
    .norm_i        (norm),
    .line_i        (line),
    .mask_i        (mask3_q),
    .gate_i        (gate3_q),
    .take_o        (take),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[design/lsnd_checker.sv]
// Port-level checks for the line sensor normalizer, bound to the top level.
module lsnd_checker import lsnd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_BITS-1:0]  m_axis_tdata
);

  localparam int unsigned STEER_LSB = NUM_LANES*NORM_BITS + MASK_BITS;

  logic [NORM_BITS-1:0]  out_left, out_right, out_center;
  logic [STEER_BITS-1:0] out_steer;

  assign out_right  = m_axis_tdata[LANE_RT*NORM_BITS +: NORM_BITS];
  assign out_center = m_axis_tdata[LANE_CT*NORM_BITS +: NORM_BITS];
  assign out_left   = m_axis_tdata[LANE_LT*NORM_BITS +: NORM_BITS];
  assign out_steer  = m_axis_tdata[STEER_LSB +: STEER_BITS];

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // With the output empty the whole pipeline is free to take an item.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  // Steering error agrees with the left and right levels of the same item.
  a_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_steer == (STEER_BITS'(out_left) - STEER_BITS'(out_right)))
    else $error("steering error does not match levels");

  // The center and left normalized levels stay inside the clamp window.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_center >= NORM_FLOOR && out_center <= NORM_MAX &&
                      out_left >= NORM_FLOOR && out_left <= NORM_MAX)
    else $error("normalized level outside clamp window");

endmodule

bind line_sensor_normalize_digitize lsnd_checker u_lsnd_checker (.*);

[test/tb_line_sensor_normalize_digitize.sv]
// Self-checking testbench for the five-lane line sensor normalizer and digitizer.
`timescale 1ns / 100ps

module tb_line_sensor_normalize_digitize;
  import lsnd_pkg::*;

  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PRINT_CAP = 40;

  // Register slots past the last threshold; writes there must be ignored.
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

  // One result item as the block should produce it.
  typedef struct packed {
    logic [NUM_LANES-1:0][NORM_BITS-1:0] level;
    logic [MASK_BITS-1:0]                line_bits;
    logic [STEER_BITS-1:0]               steer;
    logic                                gate_open;
  } sensor_result_t;

  // Scoreboard: holds the threshold copy and the queue of expected results.
  class sensor_scoreboard;
    int unsigned lo_cal[NUM_LANES] = '{180, 169, 167, 163, 175};
    int unsigned hi_cal[NUM_LANES] = '{1715, 1473, 1315, 1184, 1437};
    logic [NORM_BITS-1:0]  line_thr[NUM_LANES];
    logic [FIELD_BITS-1:0] gate_thr;
    sensor_result_t        expected_q[$];
    int unsigned           errors;

    function new();
      errors = 0;
      apply_reset();
    endfunction

    function void apply_reset();
      for (int i = 0; i < NUM_LANES; i++) line_thr[i] = 11'd1000;
      gate_thr = 12'd300;
    endfunction

    function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
      if (idx == REG_GATE) begin
        gate_thr = value[FIELD_BITS-1:0];
      end else if (idx <= REG_THR_FL) begin
        line_thr[idx] = value[NORM_BITS-1:0];
      end
    endfunction

    function logic [31:0] reg_value(logic [REG_IDX_BITS-1:0] idx);
      if (idx == REG_GATE) return 32'(gate_thr);
      return 32'(line_thr[idx]);
    endfunction

    // Integer normalization against the fixed calibration, clamped to 20..2000.
    function logic [NORM_BITS-1:0] level_of(int unsigned x, int lane);
      int unsigned n;
      if (x <= lo_cal[lane]) return NORM_BITS'(20);
      n = ((x - lo_cal[lane]) * 2000) / (hi_cal[lane] - lo_cal[lane]);
      if (n > 2000) n = 2000;
      if (n < 20) n = 20;
      return NORM_BITS'(n);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [IN_BITS-1:0] d);
      sensor_result_t r;
      logic [MASK_BITS-1:0] hits;
      hits = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        r.level[i] = level_of(int'(d[12*i +: 12]), i);
        hits[i] = (r.level[i] < line_thr[i]);
      end
      r.line_bits = hits & d[76:72];
      r.steer = STEER_BITS'({1'b0, r.level[LANE_LT]} - {1'b0, r.level[LANE_RT]});
      r.gate_open = (d[71:60] <= gate_thr);
      expected_q.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= PRINT_CAP) begin
        $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
      end
    endtask

    task check_result(logic [OUT_BITS-1:0] d);
      sensor_result_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing expected", 0, 0);
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < NUM_LANES; i++) begin
        if (d[11*i +: 11] !== want.level[i]) begin
          report($sformatf("level of lane %0d", i), d[11*i +: 11], want.level[i]);
        end
      end
      if (d[59:55] !== want.line_bits) report("line_bits", d[59:55], want.line_bits);
      if (d[71:60] !== want.steer) report("steer_error", d[71:60], want.steer);
      if (d[72] !== want.gate_open) report("gate_open", d[72], want.gate_open);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // Fields from bit 0: five samples and gate_sample (12 bits each), bit_mask (5).
  logic [IN_BITS-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // Fields from bit 0: five levels (11 bits each), line_bits, steer_error, gate_open.
  logic [OUT_BITS-1:0]  m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  sensor_scoreboard board;
  int unsigned      cycles;
  logic             calm;

  line_sensor_normalize_digitize uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls at random unless a calm stretch is running.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 15);
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Pack one set of samples into the input item layout.
  function automatic logic [IN_BITS-1:0] pack_samples(logic [NUM_LANES-1:0][11:0] s,
                                                      logic [11:0] gate,
                                                      logic [MASK_BITS-1:0] mask);
    logic [IN_BITS-1:0] d;
    d = '0;
    d[59:0] = s;
    d[71:60] = gate;
    d[76:72] = mask;
    return d;
  endfunction

  // Offer one item, with random idle cycles ahead of it outside a calm stretch.
  task automatic send_item(logic [IN_BITS-1:0] d);
    while (!calm && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(d);
  endtask

  // The bus goes idle after each transfer before the task returns.
  task automatic apb_write(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apb_check(logic [REG_IDX_BITS-1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata !== board.reg_value(idx)) begin
      board.report($sformatf("read of register %0d", idx), prdata, board.reg_value(idx));
    end
    @(posedge clk_i);
  endtask

  // Stop offering items and wait until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all six registers, with junk above the register width, and the two unused slots, then read the six back.
  task automatic load_config(logic [NUM_LANES-1:0][NORM_BITS-1:0] thr, logic [11:0] gate);
    logic [REG_IDX_BITS-1:0] idx;
    for (int i = 0; i < NUM_LANES; i++) begin
      idx = REG_IDX_BITS'(i);
      apb_write(idx, ($urandom() & 32'hFFFF_F800) | 32'(thr[i]));
    end
    apb_write(REG_GATE, ($urandom() & 32'hFFFF_F000) | 32'(gate));
    apb_write(REG_UNUSED_LO, $urandom());
    apb_write(REG_UNUSED_HI, $urandom());
    for (int i = 0; i < NUM_LANES; i++) apb_check(REG_IDX_BITS'(i));
    apb_check(REG_GATE);
  endtask

  // Samples biased toward the calibration span and its edges.
  function automatic logic [11:0] pick_sample(int lane);
    int unsigned lo;
    int unsigned hi;
    lo = board.lo_cal[lane];
    hi = board.hi_cal[lane];
    case ($urandom_range(3))
      0: return 12'($urandom_range(4095));
      3: begin
        case ($urandom_range(5))
          0: return 12'd0;
          1: return 12'(lo);
          2: return 12'(lo + 1);
          3: return 12'(hi);
          4: return 12'(hi + 1);
          default: return 12'hFFF;
        endcase
      end
      default: return 12'($urandom_range(hi + 20, lo - 20));
    endcase
  endfunction

  function automatic logic [IN_BITS-1:0] random_item();
    logic [NUM_LANES-1:0][11:0] s;
    logic [11:0] gate;
    logic [MASK_BITS-1:0] mask;
    int unsigned g;
    for (int i = 0; i < NUM_LANES; i++) s[i] = pick_sample(i);
    if ($urandom_range(1) == 0) begin
      gate = 12'($urandom_range(4095));
    end else begin
      g = int'(board.gate_thr) + $urandom_range(4) - 2;
      gate = (g > 4095) ? ((board.gate_thr < 12'd2) ? 12'd0 : 12'hFFF) : 12'(g);
    end
    mask = ($urandom_range(9) < 7) ? 5'h1F : 5'($urandom_range(31));
    return pack_samples(s, gate, mask);
  endfunction

  // Thresholds for one random phase; phase 1 uses the extremes.
  function automatic logic [NORM_BITS-1:0] pick_threshold(int unsigned phase);
    if (phase == 1) begin
      case ($urandom_range(4))
        0: return 11'd0;
        1: return 11'd2047;
        2: return 11'd2000;
        3: return 11'd2001;
        default: return 11'd20;
      endcase
    end
    return ($urandom_range(3) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(2000, 20));
  endfunction

  // Directed items: field extremes, calibration edges and mask patterns.
  task automatic run_directed();
    logic [NUM_LANES-1:0][11:0] s;
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'd0;
    send_item(pack_samples(s, 12'd0, 5'h1F));
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'hFFF;
    send_item(pack_samples(s, 12'hFFF, 5'h1F));
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'(board.lo_cal[i]);
    send_item(pack_samples(s, 12'd300, 5'h1F));
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'(board.lo_cal[i] + 1);
    send_item(pack_samples(s, 12'd301, 5'h1F));
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'(board.hi_cal[i]);
    send_item(pack_samples(s, 12'd299, 5'h1F));
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'(board.hi_cal[i] + 1);
    send_item(pack_samples(s, 12'd0, 5'h00));
    for (int i = 0; i < NUM_LANES; i++) s[i] = 12'((board.lo_cal[i] + board.hi_cal[i]) / 2);
    send_item(pack_samples(s, 12'hAAA, 5'h15));
    send_item(pack_samples(s, 12'h555, 5'h0A));
    // Far left dark against a bright right side, then the mirror case.
    s = '{12'd175, 12'd163, 12'd800, 12'd1473, 12'd1715};
    send_item(pack_samples(s, 12'd100, 5'h1F));
    s = '{12'd1437, 12'd1184, 12'd800, 12'd169, 12'd180};
    send_item(pack_samples(s, 12'd100, 5'h1F));
    s = '{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA};
    send_item(pack_samples(s, 12'h800, 5'h10));
    s = '{12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555};
    send_item(pack_samples(s, 12'h7FF, 5'h01));
  endtask

  initial begin
    logic [NUM_LANES-1:0][NORM_BITS-1:0] thr;
    logic [11:0] gate;
    int unsigned sent;
    int unsigned phase;

    board = new();
    cycles = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, then all thresholds at zero, then at their maximum.
    for (int i = 0; i < NUM_LANES; i++) apb_check(REG_IDX_BITS'(i));
    apb_check(REG_GATE);
    run_directed();
    drain();
    for (int i = 0; i < NUM_LANES; i++) thr[i] = 11'd0;
    load_config(thr, 12'd0);
    run_directed();
    drain();
    for (int i = 0; i < NUM_LANES; i++) thr[i] = 11'd2047;
    load_config(thr, 12'hFFF);
    run_directed();
    drain();

    // Random phases, each with its own thresholds; one of them runs without stalls.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int i = 0; i < NUM_LANES; i++) thr[i] = pick_threshold(phase);
      gate = (phase == 1) ? 12'hFFF : 12'($urandom_range(4095));
      load_config(thr, gate);
      calm = (phase == 3);
      for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
        send_item(random_item());
        sent++;
      end
      calm = 1'b0;
      drain();
      phase++;
    end

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
design/lsnd_pkg.sv
design/lsnd_cfg.sv
design/lsnd_lane.sv
design/lsnd_merge.sv
design/line_sensor_normalize_digitize.sv
design/lsnd_checker.sv
test/tb_line_sensor_normalize_digitize.sv
